// ===== hw/rtl/qea_pkg.sv =====
package qea_pkg;

  // arctangent unit
  localparam int CORDIC_STAGES = 16;
  localparam int STG_IDX_W     = 5;
  localparam int TAB_W         = 29;
  localparam int ATAN_IN_W     = 34;
  localparam int MAG_W         = 39;
  localparam int CORD_W        = 42;
  localparam int ANG_W         = 33;
  localparam int NORM_STAGES   = 3;
  localparam int ATAN_LAT      = 1 + NORM_STAGES + CORDIC_STAGES;

  // square root unit
  localparam int SQRT_BITS = 29;
  localparam int REM_W     = 57;
  localparam int S_W       = 30;

  // angle constants
  localparam logic signed [ANG_W-1:0] PI_Z = 33'sd1686629713;
  localparam logic signed [17:0] PI_Q13      = 18'sd25736;
  localparam logic signed [17:0] TWO_PI_Q13  = 18'sd51472;
  localparam logic signed [17:0] HALF_PI_Q13 = 18'sd12868;
  localparam logic signed [32:0] HALF_Q28    = 33'sd134217728;
  localparam logic signed [33:0] ONE_Q28     = 34'sd268435456;
  localparam logic [REM_W-1:0]   ONE_Q56     = REM_W'(1) << 56;

  typedef struct packed {
    logic signed [CORD_W-1:0] x;
    logic signed [CORD_W-1:0] y;
    logic signed [ANG_W-1:0]  z;
  } cordic_vec_t;

  typedef struct packed {
    logic [REM_W-1:0]         rem;
    logic [SQRT_BITS-1:0]     root;
    logic signed [S_W-1:0]    s;
  } sqrt_t;

  function automatic logic [TAB_W-1:0] atan_tab(input logic [STG_IDX_W-1:0] idx);
    logic [TAB_W-1:0] v;
    unique case (idx)
      5'd0:  v = 29'd421657428;
      5'd1:  v = 29'd248918915;
      5'd2:  v = 29'd131521918;
      5'd3:  v = 29'd66762579;
      5'd4:  v = 29'd33510843;
      5'd5:  v = 29'd16771758;
      5'd6:  v = 29'd8387925;
      5'd7:  v = 29'd4194219;
      5'd8:  v = 29'd2097141;
      5'd9:  v = 29'd1048575;
      5'd10: v = 29'd524288;
      5'd11: v = 29'd262144;
      5'd12: v = 29'd131072;
      5'd13: v = 29'd65536;
      5'd14: v = 29'd32768;
      5'd15: v = 29'd16384;
      5'd16: v = 29'd8192;
      5'd17: v = 29'd4096;
      5'd18: v = 29'd2048;
      5'd19: v = 29'd1024;
      5'd20: v = 29'd512;
      5'd21: v = 29'd256;
      5'd22: v = 29'd128;
      5'd23: v = 29'd64;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ===== hw/rtl/qea_cordic_cell.sv =====
module qea_cordic_cell import qea_pkg::*; (
  input  logic                 clk,
  input  logic                 en,
  input  logic [STG_IDX_W-1:0] idx,
  input  cordic_vec_t          d_in,
  output cordic_vec_t          d_out
);

  cordic_vec_t vec_r;
  cordic_vec_t vec_nxt;
  logic signed [CORD_W-1:0] xs;
  logic signed [CORD_W-1:0] ys;
  logic signed [ANG_W-1:0]  ang;

  always_comb begin
    xs      = d_in.x >>> idx;
    ys      = d_in.y >>> idx;
    ang     = ANG_W'(atan_tab(idx));
    vec_nxt = d_in;
    if (d_in.y > 0) begin
      vec_nxt.x = d_in.x + ys;
      vec_nxt.y = d_in.y - xs;
      vec_nxt.z = d_in.z + ang;
    end else if (d_in.y < 0) begin
      vec_nxt.x = d_in.x - ys;
      vec_nxt.y = d_in.y + xs;
      vec_nxt.z = d_in.z - ang;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vec_r <= vec_nxt;
    end
  end

  assign d_out = vec_r;

endmodule

// ===== hw/rtl/qea_sqrt_cell.sv =====
module qea_sqrt_cell import qea_pkg::*; (
  input  logic                 clk,
  input  logic                 en,
  input  logic [STG_IDX_W-1:0] idx,
  input  sqrt_t                d_in,
  output sqrt_t                d_out
);

  sqrt_t          sq_r;
  sqrt_t          sq_nxt;
  logic [REM_W:0] trial;

  // trial = (root + 2^idx)^2 - root^2, root holds only bits above idx
  always_comb begin
    trial  = ((REM_W+1)'(d_in.root) << (idx + 5'd1)) | ((REM_W+1)'(1) << {idx, 1'b0});
    sq_nxt = d_in;
    if ({1'b0, d_in.rem} >= trial) begin
      sq_nxt.rem  = d_in.rem - REM_W'(trial);
      sq_nxt.root = d_in.root | (SQRT_BITS'(1) << idx);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_r <= sq_nxt;
    end
  end

  assign d_out = sq_r;

endmodule

// ===== hw/rtl/qea_atan2.sv =====
module qea_atan2 import qea_pkg::*; (
  input  logic                        clk,
  input  logic                        en,
  input  logic signed [ATAN_IN_W-1:0] x_in,
  input  logic signed [ATAN_IN_W-1:0] y_in,
  output logic signed [ANG_W-1:0]     ang_out
);

  typedef struct packed {
    logic [MAG_W-1:0]         m;
    logic signed [CORD_W-1:0] x;
    logic signed [CORD_W-1:0] y;
    logic signed [ANG_W-1:0]  z;
  } norm_t;

  // shift both operands left by s when the top s bits of the magnitude are clear
  function automatic norm_t norm_step(input norm_t a, input int s);
    norm_t r;
    r = a;
    if ((a.m >> (MAG_W - s)) == '0) begin
      r.m = a.m << s;
      r.x = a.x <<< s;
      r.y = a.y <<< s;
    end
    return r;
  endfunction

  norm_t nrm_r [NORM_STAGES+1];
  norm_t nrm_nxt [NORM_STAGES+1];
  logic signed [CORD_W-1:0] xe;
  logic signed [CORD_W-1:0] ye;
  logic signed [CORD_W-1:0] y_abs;
  logic                     neg;
  cordic_vec_t              cv [CORDIC_STAGES+1];

  // left half-plane folded onto the right, starting angle +-pi
  always_comb begin
    xe               = CORD_W'(x_in);
    ye               = CORD_W'(y_in);
    neg              = x_in < 0;
    nrm_nxt[0].x     = neg ? -xe : xe;
    nrm_nxt[0].y     = neg ? -ye : ye;
    nrm_nxt[0].z     = neg ? ((y_in >= 0) ? PI_Z : -PI_Z) : '0;
    y_abs            = (nrm_nxt[0].y < 0) ? -nrm_nxt[0].y : nrm_nxt[0].y;
    nrm_nxt[0].m     = MAG_W'(nrm_nxt[0].x | y_abs);
  end

  for (genvar g = 1; g <= NORM_STAGES; g++) begin : g_norm
    always_comb begin
      nrm_nxt[g] = norm_step(norm_step(nrm_r[g-1], 32 >> (2 * (g - 1))),
                             16 >> (2 * (g - 1)));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k <= NORM_STAGES; k++) begin
        nrm_r[k] <= nrm_nxt[k];
      end
    end
  end

  always_comb begin
    cv[0].x = nrm_r[NORM_STAGES].x;
    cv[0].y = nrm_r[NORM_STAGES].y;
    cv[0].z = nrm_r[NORM_STAGES].z;
  end

  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
    qea_cordic_cell u_cell (
      .clk   (clk),
      .en    (en),
      .idx   (STG_IDX_W'(g)),
      .d_in  (cv[g]),
      .d_out (cv[g+1])
    );
  end

  assign ang_out = cv[CORDIC_STAGES].z;

endmodule

// ===== hw/rtl/quaternion_to_euler_angles_top.sv =====
// channel | direction | handshake           | payload
// in      | input     | in_valid/in_ready   | in_q_w, in_q_x, in_q_y, in_q_z (Q2.14)
// out     | output    | out_valid/out_ready | out_roll, out_pitch, out_yaw, out_pitch_clamped
// cfg     | input     | cfg_we              | cfg_wdata (declination, Q3.13)
//
// one item per cycle while not stalled; the pitch path is longest: product, operand and
// sqrt input, 29 square root cells, 20 arctangent stages, rounding and output registers
// reset clears all valid flags and the declination; no clearing pass
// a result not taken stalls the whole pipeline, and in_ready falls with it
module quaternion_to_euler_angles_top import qea_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] in_q_w,
  input  logic signed [15:0] in_q_x,
  input  logic signed [15:0] in_q_y,
  input  logic signed [15:0] in_q_z,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] out_roll,
  output logic signed [14:0] out_pitch,
  output logic signed [15:0] out_yaw,
  output logic               out_pitch_clamped,
  input  logic               cfg_we,
  input  logic signed [15:0] cfg_wdata
);

  localparam int PIPE_LAT  = 3 + SQRT_BITS + ATAN_LAT + 1;
  localparam int RY_DLY    = SQRT_BITS + 1;
  localparam int CLAMP_DLY = PIPE_LAT - 2;

  function automatic logic signed [15:0] q13_sat(input logic signed [ANG_W-1:0] z,
                                                 input logic signed [17:0] lim);
    logic signed [ANG_W:0] zr;
    logic signed [17:0]    q;
    zr = (ANG_W+1)'(z) + 34'sd32768;
    q  = 18'(zr >>> 16);
    if (q > lim) begin
      q = lim;
    end else if (q < -lim) begin
      q = -lim;
    end
    return 16'(q);
  endfunction

  logic en;
  logic [PIPE_LAT-1:0] vld_r;
  logic out_valid_r;
  logic signed [15:0] decl_r;

  // products
  logic signed [31:0] p_wx_r, p_yz_r, p_xx_r, p_yy_r, p_zz_r, p_xy_r, p_wz_r, p_wy_r, p_xz_r;
  // operand sums
  logic signed [32:0] roll_y_r, roll_x_r, yaw_y_r, yaw_x_r;
  logic signed [S_W-1:0] s_r;
  logic clamp_r;
  logic signed [32:0] roll_y_nxt, roll_x_nxt, yaw_y_nxt, yaw_x_nxt;
  logic signed [33:0] s_full;
  logic signed [S_W-1:0] s_nxt;
  logic clamp_nxt;

  logic [SQRT_BITS-1:0] s_mag;
  logic [REM_W-1:0]     s_sq;
  sqrt_t                sq [SQRT_BITS+1];

  logic signed [ANG_W-1:0] roll_z, yaw_z, pitch_z;
  logic signed [15:0] roll_pipe_r [RY_DLY+1];
  logic signed [15:0] yaw_pipe_r [RY_DLY+1];
  logic signed [15:0] pitch_r;
  logic clamp_pipe_r [CLAMP_DLY];

  logic signed [17:0] ysum;
  logic signed [17:0] ywrap;
  logic signed [17:0] ysat;

  logic signed [15:0] out_roll_r, out_yaw_r;
  logic signed [14:0] out_pitch_r;
  logic out_clamp_r;

  assign en       = !out_valid_r || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      vld_r       <= {vld_r[PIPE_LAT-2:0], in_valid};
      out_valid_r <= vld_r[PIPE_LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      decl_r <= '0;
    end else if (cfg_we) begin
      decl_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_wx_r <= in_q_w * in_q_x;
      p_yz_r <= in_q_y * in_q_z;
      p_xx_r <= in_q_x * in_q_x;
      p_yy_r <= in_q_y * in_q_y;
      p_zz_r <= in_q_z * in_q_z;
      p_xy_r <= in_q_x * in_q_y;
      p_wz_r <= in_q_w * in_q_z;
      p_wy_r <= in_q_w * in_q_y;
      p_xz_r <= in_q_x * in_q_z;
    end
  end

  // roll and yaw operands; arcsine argument clamped to unit magnitude
  always_comb begin
    roll_y_nxt = 33'(p_yz_r) + 33'(p_wx_r);
    roll_x_nxt = HALF_Q28 - (33'(p_xx_r) + 33'(p_yy_r));
    yaw_y_nxt  = 33'(p_xy_r) + 33'(p_wz_r);
    yaw_x_nxt  = HALF_Q28 - (33'(p_yy_r) + 33'(p_zz_r));
    s_full     = (34'(p_wy_r) - 34'(p_xz_r)) <<< 1;
    clamp_nxt  = 1'b0;
    s_nxt      = S_W'(s_full);
    if (s_full > ONE_Q28) begin
      s_nxt     = S_W'(ONE_Q28);
      clamp_nxt = 1'b1;
    end else if (s_full < -ONE_Q28) begin
      s_nxt     = S_W'(-ONE_Q28);
      clamp_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      roll_y_r <= roll_y_nxt;
      roll_x_r <= roll_x_nxt;
      yaw_y_r  <= yaw_y_nxt;
      yaw_x_r  <= yaw_x_nxt;
      s_r      <= s_nxt;
      clamp_r  <= clamp_nxt;
    end
  end

  // 1 - s^2 feeds the square root row
  always_comb begin
    s_mag = s_r[S_W-1] ? SQRT_BITS'(-s_r) : SQRT_BITS'(s_r);
    s_sq  = REM_W'(s_mag) * REM_W'(s_mag);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq[0].rem  <= ONE_Q56 - s_sq;
      sq[0].root <= '0;
      sq[0].s    <= s_r;
    end
  end

  for (genvar g = 0; g < SQRT_BITS; g++) begin : g_sqrt
    qea_sqrt_cell u_sqrt (
      .clk   (clk),
      .en    (en),
      .idx   (STG_IDX_W'(SQRT_BITS - 1 - g)),
      .d_in  (sq[g]),
      .d_out (sq[g+1])
    );
  end

  qea_atan2 u_roll (
    .clk     (clk),
    .en      (en),
    .x_in    (ATAN_IN_W'(roll_x_r)),
    .y_in    (ATAN_IN_W'(roll_y_r)),
    .ang_out (roll_z)
  );

  qea_atan2 u_yaw (
    .clk     (clk),
    .en      (en),
    .x_in    (ATAN_IN_W'(yaw_x_r)),
    .y_in    (ATAN_IN_W'(yaw_y_r)),
    .ang_out (yaw_z)
  );

  qea_atan2 u_pitch (
    .clk     (clk),
    .en      (en),
    .x_in    ($signed(ATAN_IN_W'(sq[SQRT_BITS].root))),
    .y_in    (ATAN_IN_W'(sq[SQRT_BITS].s)),
    .ang_out (pitch_z)
  );

  // roll and yaw wait for the pitch path
  always_ff @(posedge clk) begin
    if (en) begin
      roll_pipe_r[0] <= q13_sat(roll_z, PI_Q13);
      yaw_pipe_r[0]  <= q13_sat(yaw_z, PI_Q13);
      for (int k = 1; k <= RY_DLY; k++) begin
        roll_pipe_r[k] <= roll_pipe_r[k-1];
        yaw_pipe_r[k]  <= yaw_pipe_r[k-1];
      end
      pitch_r         <= q13_sat(pitch_z, HALF_PI_Q13);
      clamp_pipe_r[0] <= clamp_r;
      for (int k = 1; k < CLAMP_DLY; k++) begin
        clamp_pipe_r[k] <= clamp_pipe_r[k-1];
      end
    end
  end

  // declination, one wrap, then saturation
  always_comb begin
    ysum  = 18'(yaw_pipe_r[RY_DLY]) + 18'(decl_r);
    ywrap = ysum;
    if (ysum < -PI_Q13) begin
      ywrap = ysum + TWO_PI_Q13;
    end else if (ysum > PI_Q13) begin
      ywrap = ysum - TWO_PI_Q13;
    end
    ysat = ywrap;
    if (ywrap > PI_Q13) begin
      ysat = PI_Q13;
    end else if (ywrap < -PI_Q13) begin
      ysat = -PI_Q13;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_roll_r  <= roll_pipe_r[RY_DLY];
      out_pitch_r <= 15'(pitch_r);
      out_yaw_r   <= 16'(ysat);
      out_clamp_r <= clamp_pipe_r[CLAMP_DLY-1];
    end
  end

  assign out_valid         = out_valid_r;
  assign out_roll          = out_roll_r;
  assign out_pitch         = out_pitch_r;
  assign out_yaw           = out_yaw_r;
  assign out_pitch_clamped = out_clamp_r;

endmodule
